@@ rtl/tse_pkg.sv @@
// types, constants and decode patterns for the thumb subtract execute unit
package tse_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_EXEC  = 2'd0,
    ST_UNPRED = 2'd1,
    ST_NOTSUB = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic        is_wide;
    logic [31:0] rn_value;
    logic [31:0] rm_value;
    logic        carry_in;
    logic        in_it_block;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  dest_reg;
    logic [31:0] result;
    logic        write_result;
    logic        write_flags;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  dest_reg;
    logic [31:0] x;
    logic [31:0] y;
    logic        cin;
    logic        setf;
  } op_t;

  localparam logic [15:0] PatNegT1   = 16'h4240, MskNegT1   = 16'hFFC0;
  localparam logic [15:0] PatSbcT1   = 16'h4180, MskSbcT1   = 16'hFFC0;
  localparam logic [15:0] PatSubspT1 = 16'hB080, MskSubspT1 = 16'hFF80;
  localparam logic [15:0] PatSubiT1  = 16'h1E00, MskSubiT1  = 16'hFE00;
  localparam logic [15:0] PatSubiT2  = 16'h3800, MskSubiT2  = 16'hF800;
  localparam logic [15:0] PatSubrT1  = 16'h1A00, MskSubrT1  = 16'hFE00;
  localparam logic [31:0] PatSubiT3  = 32'hF1A00000, MskSubiT3  = 32'hFBE08000;
  localparam logic [31:0] PatSubrT2  = 32'hEBA00000, MskSubrT2  = 32'hFFE08000;
  localparam logic [31:0] PatRsbrT1  = 32'hEBC00000, MskRsbrT1  = 32'hFFE08000;
  localparam logic [31:0] PatSubspT2 = 32'hF1AD0000, MskSubspT2 = 32'hFBEF8000;

  localparam logic [3:0] RegSp = 4'd13;
  localparam logic [3:0] RegPc = 4'd15;

endpackage

@@ rtl/tse_front.sv @@
// front part: decodes the instruction, expands immediates, builds adder operands
module tse_front import tse_pkg::*; (
  input  in_item_t item_i,
  output op_t      op_o
);

  logic [11:0] imm12;
  logic [7:0]  b8;
  logic [31:0] eimm, rot_src;
  logic        badimm;
  logic [4:0]  rot, imm5;
  logic [31:0] sh, v;
  logic [15:0] h;
  logic [31:0] w;
  logic [3:0]  rd, n, m;
  logic        s;

  assign w = item_i.instruction;
  assign h = w[15:0];
  assign v = item_i.rm_value;
  assign s = w[20];
  assign n = w[19:16];
  assign m = w[3:0];
  assign rd = w[11:8];
  assign imm12 = {w[26], w[14:12], w[7:0]};
  assign b8 = imm12[7:0];
  assign rot = imm12[11:7];
  assign rot_src = {24'd0, 1'b1, imm12[6:0]};
  assign imm5 = {w[14:12], w[7:6]};

  always_comb begin
    badimm = 1'b0;
    if (imm12[11:10] == 2'b00) begin
      badimm = (imm12[9:8] != 2'b00) && (b8 == 8'd0);
      case (imm12[9:8])
        2'd0:    eimm = {24'd0, b8};
        2'd1:    eimm = {8'd0, b8, 8'd0, b8};
        2'd2:    eimm = {b8, 8'd0, b8, 8'd0};
        default: eimm = {b8, b8, b8, b8};
      endcase
    end else begin
      eimm = (rot_src >> rot) | (rot_src << (6'd32 - {1'b0, rot}));
    end
  end

  always_comb begin
    case (w[5:4])
      2'd0:    sh = v << imm5;
      2'd1:    sh = (imm5 == 5'd0) ? 32'd0 : v >> imm5;
      2'd2:    sh = (imm5 == 5'd0) ? {32{v[31]}} : 32'($signed(v) >>> imm5);
      default: sh = (imm5 == 5'd0) ? {item_i.carry_in, v[31:1]} :
                    ((v >> imm5) | (v << (6'd32 - {1'b0, imm5})));
    endcase
  end

  always_comb begin
    op_o.status   = ST_EXEC;
    op_o.dest_reg = 4'd0;
    op_o.x        = item_i.rn_value;
    op_o.y        = 32'd0;
    op_o.cin      = 1'b1;
    op_o.setf     = 1'b0;
    if (!item_i.is_wide) begin
      op_o.setf = !item_i.in_it_block;
      if ((h & MskNegT1) == PatNegT1) begin
        op_o.dest_reg = {1'b0, h[2:0]};
        op_o.x = ~item_i.rn_value;
      end else if ((h & MskSbcT1) == PatSbcT1) begin
        op_o.dest_reg = {1'b0, h[2:0]};
        op_o.y = ~v;
        op_o.cin = item_i.carry_in;
      end else if ((h & MskSubspT1) == PatSubspT1) begin
        op_o.dest_reg = RegSp;
        op_o.y = ~{23'd0, h[6:0], 2'b00};
        op_o.setf = 1'b0;
      end else if ((h & MskSubiT1) == PatSubiT1) begin
        op_o.dest_reg = {1'b0, h[2:0]};
        op_o.y = ~{29'd0, h[8:6]};
      end else if ((h & MskSubiT2) == PatSubiT2) begin
        op_o.dest_reg = {1'b0, h[10:8]};
        op_o.y = ~{24'd0, h[7:0]};
      end else if ((h & MskSubrT1) == PatSubrT1) begin
        op_o.dest_reg = {1'b0, h[2:0]};
        op_o.y = ~v;
      end else begin
        op_o.status = ST_NOTSUB;
      end
    end else begin
      op_o.dest_reg = rd;
      op_o.setf = s;
      if ((w & MskSubspT2) == PatSubspT2) begin
        if (rd == RegPc && s) op_o.status = ST_NOTSUB;
        else if (rd == RegPc || badimm) op_o.status = ST_UNPRED;
        op_o.y = ~eimm;
      end else if ((w & MskSubiT3) == PatSubiT3) begin
        if (rd == RegPc && s) op_o.status = ST_NOTSUB;
        else if (rd == RegSp || rd == RegPc || n == RegPc || badimm)
          op_o.status = ST_UNPRED;
        op_o.y = ~eimm;
      end else if ((w & MskSubrT2) == PatSubrT2) begin
        if ((rd == RegPc && s) || n == RegSp) op_o.status = ST_NOTSUB;
        else if (rd == RegSp || rd == RegPc || n == RegPc || m == RegSp || m == RegPc)
          op_o.status = ST_UNPRED;
        op_o.y = ~sh;
      end else if ((w & MskRsbrT1) == PatRsbrT1) begin
        if (rd == RegSp || rd == RegPc || n == RegSp || n == RegPc ||
            m == RegSp || m == RegPc)
          op_o.status = ST_UNPRED;
        op_o.x = ~item_i.rn_value;
        op_o.y = sh;
      end else begin
        op_o.status = ST_NOTSUB;
      end
    end
  end

endmodule

@@ rtl/tse_queue.sv @@
// short fifo between the front and back parts
module tse_queue import tse_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  data_o,
  output logic empty_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  op_t              mem_q [Depth];
  logic [Aw-1:0]    wr_q, rd_q;
  logic [Aw:0]      cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

endmodule

@@ rtl/tse_back.sv @@
// back part: add with carry, flags, output register
module tse_back import tse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  op_t       op_i,
  input  logic      op_valid_i,
  output logic      op_pop_o,
  output out_item_t item_o,
  output logic      valid_o,
  input  logic      stall_i
);

  logic [32:0] sum;
  out_item_t   res;
  out_item_t   item_q;
  logic        valid_q;

  assign sum = {1'b0, op_i.x} + {1'b0, op_i.y} + 33'(op_i.cin);

  always_comb begin
    res = '0;
    res.status = op_i.status;
    if (op_i.status == ST_EXEC) begin
      res.dest_reg = op_i.dest_reg;
      res.result = sum[31:0];
      res.write_result = 1'b1;
      if (op_i.setf) begin
        res.write_flags = 1'b1;
        res.flag_n = sum[31];
        res.flag_z = (sum[31:0] == 32'd0);
        res.flag_c = sum[32];
        res.flag_v = (op_i.x[31] ^ sum[31]) & (op_i.y[31] ^ sum[31]);
      end
    end
  end

  assign op_pop_o = op_valid_i && (!valid_q || !stall_i);
  assign item_o = item_q;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i) begin
    if (op_pop_o) item_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (op_pop_o) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

@@ rtl/thumb_subtract_execute_unit.sv @@
// top level of the thumb subtract execute unit
//   channel | direction | handshake          | payload
//   input   | in        | in_valid_i/stall_o | in_item_i
//   output  | out       | out_valid_o/stall_i| out_item_o
// one item per cycle sustained while the output is not stalled; an accepted item is written
// into the queue, then loaded from the queue head into the output register that drives result valid.
// reset clears the queue pointers and the output valid.
// input stalls only when the queue is full; the queue absorbs output stalls.
module thumb_subtract_execute_unit import tse_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  op_t  front_op, queue_op;
  logic full, empty, pop;

  tse_front u_front (
    .item_i (in_item_i),
    .op_o   (front_op)
  );

  tse_queue #(.Depth(Depth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && !full),
    .data_i  (front_op),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_op),
    .empty_o (empty)
  );

  tse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (queue_op),
    .op_valid_i (!empty),
    .op_pop_o   (pop),
    .item_o     (out_item_o),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i)
  );

  assign in_stall_o = full;

endmodule

@@ test/tse_checker.sv @@
// checker for the thumb subtract execute unit: predicts and compares each result item
`timescale 1ns / 100ps
module tse_checker import tse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  out_item_t exec_q[$];

  function automatic logic [31:0] ror32(logic [31:0] v, logic [4:0] n);
    return (v >> n) | (v << (6'd32 - n));
  endfunction

  function automatic logic [31:0] expand_mod_imm(logic [31:0] w, output logic bad);
    logic [11:0] imm12;
    logic [7:0]  b;
    imm12 = {w[26], w[14:12], w[7:0]};
    b = imm12[7:0];
    bad = 1'b0;
    if (imm12[11:10] == 2'b00) begin
      if (imm12[9:8] != 2'b00 && b == 8'd0) bad = 1'b1;
      case (imm12[9:8])
        2'd0: return {24'd0, b};
        2'd1: return {8'd0, b, 8'd0, b};
        2'd2: return {b, 8'd0, b, 8'd0};
        default: return {b, b, b, b};
      endcase
    end
    return ror32({24'd0, 1'b1, imm12[6:0]}, imm12[11:7]);
  endfunction

  function automatic logic [31:0] shifted_rm(logic [31:0] v, logic [1:0] kind,
                                             logic [4:0] imm5, logic c);
    case (kind)
      2'd0: return v << imm5;
      2'd1: return (imm5 == 0) ? 32'd0 : v >> imm5;
      2'd2: return (imm5 == 0) ? {32{v[31]}} : 32'($signed(v) >>> imm5);
      default: return (imm5 == 0) ? {c, v[31:1]} : ror32(v, imm5);
    endcase
  endfunction

  function automatic out_item_t predict_subtract(in_item_t it);
    out_item_t r;
    logic [31:0] w, x, y, sh, res;
    logic [15:0] h;
    logic [32:0] sum;
    logic [3:0]  rd, rn, rm;
    logic [1:0]  st;
    logic        cin, setf, badimm, s;
    w = it.instruction; h = w[15:0];
    st = ST_EXEC; rd = '0; x = '0; y = '0; cin = 1'b1; setf = 1'b0; badimm = 1'b0;
    r = '0;
    if (!it.is_wide) begin
      setf = !it.in_it_block;
      if ((h & MskNegT1) == PatNegT1) begin
        rd = {1'b0, h[2:0]}; x = ~it.rn_value; y = '0;
      end else if ((h & MskSbcT1) == PatSbcT1) begin
        rd = {1'b0, h[2:0]}; x = it.rn_value; y = ~it.rm_value; cin = it.carry_in;
      end else if ((h & MskSubspT1) == PatSubspT1) begin
        rd = RegSp; x = it.rn_value; y = ~{23'd0, h[6:0], 2'b00}; setf = 1'b0;
      end else if ((h & MskSubiT1) == PatSubiT1) begin
        rd = {1'b0, h[2:0]}; x = it.rn_value; y = ~{29'd0, h[8:6]};
      end else if ((h & MskSubiT2) == PatSubiT2) begin
        rd = {1'b0, h[10:8]}; x = it.rn_value; y = ~{24'd0, h[7:0]};
      end else if ((h & MskSubrT1) == PatSubrT1) begin
        rd = {1'b0, h[2:0]}; x = it.rn_value; y = ~it.rm_value;
      end else st = ST_NOTSUB;
    end else begin
      s = w[20]; rn = w[19:16]; rm = w[3:0]; rd = w[11:8]; setf = s;
      sh = shifted_rm(it.rm_value, w[5:4], {w[14:12], w[7:6]}, it.carry_in);
      if ((w & MskSubspT2) == PatSubspT2) begin
        if (rd == RegPc && s) st = ST_NOTSUB;
        else if (rd == RegPc) st = ST_UNPRED;
        x = it.rn_value; y = ~expand_mod_imm(w, badimm);
      end else if ((w & MskSubiT3) == PatSubiT3) begin
        if (rd == RegPc && s) st = ST_NOTSUB;
        else if (rd == RegSp || rd == RegPc || rn == RegPc) st = ST_UNPRED;
        x = it.rn_value; y = ~expand_mod_imm(w, badimm);
      end else if ((w & MskSubrT2) == PatSubrT2) begin
        if ((rd == RegPc && s) || rn == RegSp) st = ST_NOTSUB;
        else if (rd == RegSp || rd == RegPc || rn == RegPc || rm == RegSp || rm == RegPc)
          st = ST_UNPRED;
        x = it.rn_value; y = ~sh;
      end else if ((w & MskRsbrT1) == PatRsbrT1) begin
        if (rd == RegSp || rd == RegPc || rn == RegSp || rn == RegPc ||
            rm == RegSp || rm == RegPc) st = ST_UNPRED;
        x = ~it.rn_value; y = sh;
      end else st = ST_NOTSUB;
      if (st == ST_EXEC && badimm) st = ST_UNPRED;
    end
    r.status = st;
    if (st == ST_EXEC) begin
      sum = {1'b0, x} + {1'b0, y} + 33'(cin);
      res = sum[31:0];
      r.dest_reg = rd; r.result = res; r.write_result = 1'b1;
      if (setf) begin
        r.write_flags = 1'b1; r.flag_n = res[31]; r.flag_z = (res == 0);
        r.flag_c = sum[32]; r.flag_v = (x[31] ~^ y[31]) & (x[31] ^ res[31]);
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = exec_q.size();

  always @(posedge clk_i) begin
    out_item_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) exec_q.push_back(predict_subtract(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (exec_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count_o++;
        end else begin
          e = exec_q.pop_front();
          check_field("status", 32'(e.status), 32'(out_item_i.status));
          check_field("dest_reg", 32'(e.dest_reg), 32'(out_item_i.dest_reg));
          check_field("result", e.result, out_item_i.result);
          check_field("write_result", 32'(e.write_result), 32'(out_item_i.write_result));
          check_field("write_flags", 32'(e.write_flags), 32'(out_item_i.write_flags));
          check_field("flag_n", 32'(e.flag_n), 32'(out_item_i.flag_n));
          check_field("flag_z", 32'(e.flag_z), 32'(out_item_i.flag_z));
          check_field("flag_c", 32'(e.flag_c), 32'(out_item_i.flag_c));
          check_field("flag_v", 32'(e.flag_v), 32'(out_item_i.flag_v));
        end
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
// stimulus and verdict for the thumb subtract execute unit
`timescale 1ns / 100ps
module tb_top;
  import tse_pkg::*;

  localparam int StallLimit = 2000;

  logic      clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_item;
  out_item_t out_item;
  int        fail_count, pending, idle_pct, stall_pct, quiet_cycles;
  bit        timed_out;

  thumb_subtract_execute_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_item_i(in_item), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_item_o(out_item)
  );

  tse_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_item_i(in_item), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_item_i(out_item), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
  end

  // random item biased toward the subtract encodings
  function automatic in_item_t random_item();
    in_item_t it;
    logic [31:0] w;
    w = $urandom();
    it.is_wide = 1'b0;
    case ($urandom_range(11))
      0: w[15:6] = PatNegT1[15:6];
      1: w[15:6] = PatSbcT1[15:6];
      2: w[15:7] = PatSubspT1[15:7];
      3: w[15:9] = PatSubiT1[15:9];
      4: w[15:11] = PatSubiT2[15:11];
      5: w[15:9] = PatSubrT1[15:9];
      6: begin w = (w & ~MskSubiT3) | PatSubiT3; it.is_wide = 1'b1; end
      7: begin w = (w & ~MskSubrT2) | PatSubrT2; it.is_wide = 1'b1; end
      8: begin w = (w & ~MskRsbrT1) | PatRsbrT1; it.is_wide = 1'b1; end
      9: begin w = (w & ~MskSubspT2) | PatSubspT2; it.is_wide = 1'b1; end
      default: it.is_wide = 1'($urandom_range(1));
    endcase
    it.instruction = w;
    it.rn_value = ($urandom_range(7) == 0) ? {32{$urandom_range(1) == 1}} : $urandom();
    it.rm_value = ($urandom_range(7) == 0) ? 32'h8000_0000 : $urandom();
    it.carry_in = 1'($urandom_range(1));
    it.in_it_block = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_item_t make_item(logic [31:0] w, int wide, logic [31:0] rn,
                                         logic [31:0] rm, int c, int itb);
    in_item_t it;
    it.instruction = w; it.is_wide = 1'(wide); it.rn_value = rn; it.rm_value = rm;
    it.carry_in = 1'(c); it.in_it_block = 1'(itb);
    return it;
  endfunction

  initial begin
    in_item_t directed[$];
    rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; in_item = '0;
    idle_pct = 0; stall_pct = 0; quiet_cycles = 0; timed_out = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed.push_back(make_item(32'h0000_4240, 0, 32'h0, 0, 0, 0));          // neg zero
    directed.push_back(make_item(32'hFFFF_4247, 0, 32'h8000_0000, 0, 1, 1)); // neg min, in it
    directed.push_back(make_item(32'h0000_41BF, 0, 32'h0, 32'hFFFF_FFFF, 0, 0));
    directed.push_back(make_item(32'h0000_4180, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0));
    directed.push_back(make_item(32'h0000_B0FF, 0, 32'h0000_0100, 0, 0, 0));
    directed.push_back(make_item(32'h0000_1FFF, 0, 32'h0000_0007, 0, 0, 0));
    directed.push_back(make_item(32'h0000_3FFF, 0, 32'h8000_0000, 0, 0, 0));
    directed.push_back(make_item(32'h0000_1BFF, 0, 32'h8000_0000, 32'h1, 0, 0));
    directed.push_back(make_item(32'h0000_0000, 0, 32'h1, 32'h1, 0, 0));     // not subtract
    directed.push_back(make_item(32'hF1B1_0F00, 1, 32'h5, 0, 0, 0));         // compare alias
    directed.push_back(make_item(32'hF1A1_0D01, 1, 32'h5, 0, 0, 0));         // rd sp
    directed.push_back(make_item(32'hF1AF_0101, 1, 32'h5, 0, 0, 0));         // rn pc
    directed.push_back(make_item(32'hF1B1_0100, 1, 32'h5, 0, 0, 0));         // zero byte imm
    directed.push_back(make_item(32'hF5B1_7180, 1, 32'h5, 0, 0, 0));         // rotated imm
    directed.push_back(make_item(32'hF1B1_03FF, 1, 32'hFFFF_FFFF, 0, 0, 0));
    directed.push_back(make_item(32'hF1AD_0F01, 1, 32'h5, 0, 0, 0));         // sp, rd pc
    directed.push_back(make_item(32'hF1BD_0D01, 1, 32'h5, 0, 0, 0));
    directed.push_back(make_item(32'hEBBD_0102, 1, 32'h5, 32'h3, 0, 0));     // rn sp form
    directed.push_back(make_item(32'hEBB1_010D, 1, 32'h5, 32'h3, 0, 0));     // rm sp
    directed.push_back(make_item(32'hEBB1_0132, 1, 32'h5, 32'h3, 1, 0));     // rrx
    directed.push_back(make_item(32'hEBB1_7122, 1, 32'h5, 32'h8000_0000, 0, 0)); // asr 28
    directed.push_back(make_item(32'hEBD1_0112, 1, 32'h5, 32'h80, 0, 0));    // rsb lsr 32
    directed.push_back(make_item(32'hEBD1_71C2, 1, 32'h5, 32'h3, 0, 0));     // rsb lsl 31
    directed.push_back(make_item(32'hEBCF_0102, 1, 32'h5, 32'h3, 0, 0));     // rsb rn pc
    foreach (directed[i]) send_item(directed[i]);
    for (int i = 0; i < 1950; i++) begin
      case (i / 400)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 57; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 57; end
        3: begin idle_pct = 13; stall_pct = 13; end
        default: begin idle_pct = (i % 100 < 50) ? 0 : 57; stall_pct = idle_pct; end
      endcase
      send_item(random_item());
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0 && quiet_cycles < StallLimit) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending != 0) timed_out = 1'b1;
    if (fail_count == 0 && !timed_out) $display("[thumb_subtract_execute_unit] OK");
    else $display("[thumb_subtract_execute_unit] ERROR");
    $finish;
  end

  // stuck handshake during stimulus
  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("[thumb_subtract_execute_unit] ERROR");
    $finish;
  end

endmodule
